FILE: design/bvma_pkg.sv
// Shared types and constants for the battery voltage moving-average unit.
// No dependencies; imported by the interfaces, the divider and the top level.
`default_nettype none

package bvma_pkg;

   // Fixed field widths of the channels
   localparam int SAMPLE_W  = 12;
   localparam int AVG_W     = 12;
   localparam int MV_W      = 16;
   localparam int SCALE_W   = 20;
   localparam int RATIO_W   = 7;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 20;
   localparam int Q_FRAC    = 16;

   // Register reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(52800);
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(11);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Q16     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_RATIO = CSR_IDX_W'(1);

   // Divider control and status
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: design/bvma_if.sv
// Handshake channels of the battery voltage moving-average unit.
// Depends on bvma_pkg for the payload widths.
`default_nettype none

interface bvma_req_if
   import bvma_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bvma_rsp_if
   import bvma_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [AVG_W-1:0] average;
   logic [MV_W-1:0]  voltage_mv;
   logic             saturated;

   modport source (output valid, output average, output voltage_mv, output saturated,
                   input ready);
   modport sink   (input valid, input average, input voltage_mv, input saturated,
                   output ready);
endinterface

interface bvma_csr_if
   import bvma_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/bvma_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bvma_pkg for the control and status structs.
`default_nettype none

module bvma_div
   import bvma_pkg::*;
#(
   parameter int DW = 17,
   parameter int VW = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire div_ctrl_type  ctrl,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output div_stat_type       stat,
   output logic [DW-1:0]      quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    q_ff;
   logic [VW-1:0]    r_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [VW:0]      trial_in;
   logic             qbit_in;

   assign trial_in = {r_ff, q_ff[DW-1]};
   assign qbit_in  = (trial_in >= {1'b0, divisor});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DW);
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: shift the dividend out, the quotient in
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         q_ff <= dividend;
         r_ff <= '0;
      end else if (busy_ff) begin
         q_ff <= {q_ff[DW-2:0], qbit_in};
         if (qbit_in) begin
            r_ff <= VW'(trial_in - {1'b0, divisor});
         end else begin
            r_ff <= trial_in[VW-1:0];
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

`default_nettype wire

FILE: design/battery_voltage_moving_average_unit.sv
// Top level of the battery voltage moving-average unit.
// Depends on bvma_pkg, the channel interfaces in bvma_if and the divider bvma_div.
`default_nettype none

// Each item on req_ch carries one raw ADC sample. The sample goes into a ring of
// WINDOW entries held in a single-port synchronous memory; the unit keeps a running
// sum and a fill count, so the mean covers the samples stored so far until the ring
// is full and the whole window afterwards (a zero sample counts like any other).
// The mean is truncated, then scaled as mean * scale_q16 * divider_ratio / 65536 in
// two registered multiplies and clamped to 65535 mV with a saturated flag. One item
// is in flight at a time: after acceptance it passes the ring and sum update, the
// bit-serial divider of SUM_W = min(ADC_BITS,12) + clog2(WINDOW+1) quotient bits,
// one per cycle, the two multiplies and the result register. req_ch is ready again
// as soon as the result is loaded, while the result may still wait on rsp_ch. The
// ring needs no clearing after reset: an entry is read back for eviction only once
// the ring is full. Configuration writes on csr_ch are always ready and take effect
// at once; write them only while the unit is idle.

module battery_voltage_moving_average_unit
   import bvma_pkg::*;
#(
   parameter int WINDOW   = 20,
   parameter int ADC_BITS = 12
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bvma_req_if.sink   req_ch,
   bvma_rsp_if.source rsp_ch,
   bvma_csr_if.sink   csr_ch
);

   // Stored sample width: the field carries 12 bits, ADC_BITS may mask further
   localparam int SW    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
   localparam int CW    = $clog2(WINDOW + 1);
   localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = SW + CW;
   localparam int P1_W  = SW + SCALE_W;
   localparam int P2_W  = P1_W + RATIO_W;
   localparam int MVX_W = P2_W - Q_FRAC;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_START,
      S_DIV,
      S_MUL1,
      S_MUL2,
      S_FIN
   } state_type;

   state_type        state_ff;

   // Configuration registers
   logic [SCALE_W-1:0] scale_ff;
   logic [RATIO_W-1:0] ratio_ff;

   // Filter state
   logic [SW-1:0]    ring_mem [WINDOW];
   logic [SW-1:0]    ring_rd_ff;
   logic [IW-1:0]    write_index_ff;
   logic [CW-1:0]    fill_ff;
   logic [SUM_W-1:0] sum_ff;

   // Item datapath
   logic [SW-1:0]    sample_ff;
   logic [SW-1:0]    avg_ff;
   logic [P1_W-1:0]  prod1_ff;
   logic [P2_W-1:0]  prod2_ff;

   // Result register
   logic             rsp_valid_ff;
   logic [AVG_W-1:0] rsp_average_ff;
   logic [MV_W-1:0]  rsp_mv_ff;
   logic             rsp_sat_ff;

   logic             req_accept;
   logic             full;
   logic [SUM_W-1:0] sum_in;
   logic [IW-1:0]    write_index_in;
   logic [MVX_W-1:0] mv_wide;
   logic             sat_in;
   logic             out_free;

   div_ctrl_type     div_ctrl;
   div_stat_type     div_stat;
   logic [SUM_W-1:0] quotient;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign full = (fill_ff == CW'(WINDOW));

   // Evict the oldest sample once the ring is full, then add the new one
   always_comb begin
      if (full) begin
         sum_in = sum_ff - SUM_W'(ring_rd_ff) + SUM_W'(sample_ff);
      end else begin
         sum_in = sum_ff + SUM_W'(sample_ff);
      end
   end

   assign write_index_in = (write_index_ff == IW'(WINDOW - 1)) ? '0
                                                                : write_index_ff + IW'(1);

   // Drop the fraction bits and clamp to the millivolt field
   assign mv_wide  = prod2_ff[P2_W-1:Q_FRAC];
   assign sat_in   = (mv_wide > MVX_W'({MV_W{1'b1}}));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign div_ctrl.start = (state_ff == S_START);

   // Ring memory: read the slot at acceptance, write it back in the following cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ring_rd_ff <= ring_mem[write_index_ff];
      end
      if (state_ff == S_UPDATE) begin
         ring_mem[write_index_ff] <= sample_ff;
      end
   end

   // Configuration writes; indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         ratio_ff <= RATIO_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_SCALE_Q16:     scale_ff <= csr_ch.data[SCALE_W-1:0];
            CSR_DIVIDER_RATIO: ratio_ff <= csr_ch.data[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer with filter state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         write_index_ff <= '0;
         fill_ff        <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               sum_ff         <= sum_in;
               write_index_ff <= write_index_in;
               if (!full) begin
                  fill_ff <= fill_ff + CW'(1);
               end
               state_ff <= S_START;
            end
            S_START: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_stat.done) begin
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               // Hold here while the previous result still waits
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_ch.sample[SW-1:0];
      end
      if (state_ff == S_DIV && div_stat.done) begin
         avg_ff <= quotient[SW-1:0];
      end
      if (state_ff == S_MUL1) begin
         prod1_ff <= P1_W'(avg_ff) * P1_W'(scale_ff);
      end
      if (state_ff == S_MUL2) begin
         prod2_ff <= P2_W'(prod1_ff) * P2_W'(ratio_ff);
      end
      if (state_ff == S_FIN && out_free) begin
         rsp_average_ff <= AVG_W'(avg_ff);
         rsp_sat_ff     <= sat_in;
         rsp_mv_ff      <= sat_in ? {MV_W{1'b1}} : mv_wide[MV_W-1:0];
      end
   end

   bvma_div #(
      .DW (SUM_W),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.average    = rsp_average_ff;
   assign rsp_ch.voltage_mv = rsp_mv_ff;
   assign rsp_ch.saturated  = rsp_sat_ff;

   // One item at a time: no second acceptance right after the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ch.ready)
      else $error("item accepted while another is in flight");

   // The fill count grows by one per item until the ring is full
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && !full) |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("fill count did not advance");

   // Divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   // The captured mean is the truncated quotient of sum by fill count
   a_mean_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL1) |->
         ((SUM_W'(avg_ff) * SUM_W'(fill_ff) <= sum_ff) &&
          ((SUM_W + 1)'(avg_ff) * (SUM_W + 1)'(fill_ff) + (SUM_W + 1)'(fill_ff)
             > (SUM_W + 1)'(sum_ff))))
      else $error("mean does not match running sum and fill count");

endmodule

`default_nettype wire
